/* rtl/oled_fb_pkg.sv */
// Shared constants and codes for the OLED frame buffer with dirty-page refresh.
package oled_fb_pkg;

    localparam int COLUMNS          = 128;
    localparam int PAGES            = 8;
    localparam int BYTES_PER_RESULT = 8;

    localparam int ROW_W  = 8 * PAGES;
    localparam int CAW    = $clog2(COLUMNS);
    localparam int CW     = $clog2(COLUMNS + 1);
    localparam int PAW    = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int KW     = (BYTES_PER_RESULT > 1) ? $clog2(BYTES_PER_RESULT) : 1;
    localparam int PACK_W = 8 * BYTES_PER_RESULT;
    localparam int CNT_W  = 4;

    localparam int CMD_BYTES = 3;
    localparam int FIRST_CMD_CHUNK = (CMD_BYTES > BYTES_PER_RESULT) ? BYTES_PER_RESULT
                                                                    : CMD_BYTES;

    localparam logic [7:0] CMD_PAGE   = 8'hB0;
    localparam logic [7:0] CMD_COL_LO = 8'h00;
    localparam logic [7:0] CMD_COL_HI = 8'h10;
    localparam logic [7:0] NIB_MASK   = 8'h0F;

    typedef enum logic [1:0] {
        OP_DRAW    = 2'd0,
        OP_CLEAR   = 2'd1,
        OP_FULL    = 2'd2,
        OP_PARTIAL = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CI_PAGE   = 2'd0,
        CI_COL_LO = 2'd1,
        CI_COL_HI = 2'd2,
        CI_DONE   = 2'd3
    } cmd_idx_t;

endpackage

/* rtl/oled_framebuffer_dirty_refresh.sv */
// Page-mode OLED frame buffer with shadow store and dirty-column page refresh.
// Draw reads the column row and writes it back with the pixel set; clear drops only the frame
// store's valid flags; partial refresh adds a column scan through the shared read port.
// Throughput: one item at a time, ready only when idle; bound by one memory read per column.
// Reset: per-column valid flags of both stores clear at once, so both read as zero;
// no clearing pass is needed and the block is ready as soon as reset is released.
module oled_framebuffer_dirty_refresh (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // operation[1:0], pixel_x[9:2], pixel_y[17:10], pixel_on[18], page_index[21:19]
    input  logic [23:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // byte_count[3:0], packed_bytes[67:4]
    output logic [71:0] m_tdata,
    // is_data[0]
    output logic        m_tuser,
    output logic        m_tlast
);

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_DRAW_RD = 7'b0000010,
        ST_DRAW_WR = 7'b0000100,
        ST_SCAN    = 7'b0001000,
        ST_CGATHER = 7'b0010000,
        ST_DGATHER = 7'b0100000,
        ST_EMIT    = 7'b1000000
    } state_t;

    typedef logic [oled_fb_pkg::BYTES_PER_RESULT-1:0][7:0] pack_t;

    // storage
    logic [oled_fb_pkg::ROW_W-1:0] frame_mem  [oled_fb_pkg::COLUMNS];
    logic [oled_fb_pkg::ROW_W-1:0] shadow_mem [oled_fb_pkg::COLUMNS];
    logic [oled_fb_pkg::COLUMNS-1:0] frame_vld_reg, shadow_vld_reg;
    logic [oled_fb_pkg::ROW_W-1:0] frd_data_reg, srd_data_reg;
    logic                          frd_vld_reg, srd_vld_reg;

    // control and payload
    state_t                        state_reg, state_next;
    logic [oled_fb_pkg::CAW-1:0]   x_reg, x_next;
    logic [oled_fb_pkg::PAW-1:0]   ypage_reg, ypage_next;
    logic [2:0]                    ybit_reg, ybit_next;
    logic                          on_reg, on_next;
    logic [oled_fb_pkg::PAW-1:0]   page_reg, page_next;
    logic                          partial_reg, partial_next;
    logic [oled_fb_pkg::CW-1:0]    col_reg, col_next;
    logic [oled_fb_pkg::CAW-1:0]   rcol_reg, rcol_next;
    logic                          rvld_reg, rvld_next;
    logic                          found_reg, found_next;
    logic [oled_fb_pkg::CAW-1:0]   first_reg, first_next;
    logic [oled_fb_pkg::CAW-1:0]   last_reg, last_next;
    logic [1:0]                    cidx_reg, cidx_next;
    logic [oled_fb_pkg::CNT_W-1:0] chunk_reg, chunk_next;
    logic [oled_fb_pkg::CNT_W-1:0] k_reg, k_next;
    logic [oled_fb_pkg::CNT_W-1:0] iss_reg, iss_next;
    pack_t                         pack_reg, pack_next;
    logic                          is_data_reg, is_data_next;
    logic                          mlast_reg, mlast_next;

    // memory port controls
    logic                          rd_en;
    logic [oled_fb_pkg::CAW-1:0]   rd_addr;
    logic                          fwr_en, swr_en, fclr;
    logic [oled_fb_pkg::CAW-1:0]   fwr_addr, swr_addr;
    logic [oled_fb_pkg::ROW_W-1:0] fwr_data, swr_data;

    // input fields
    logic [1:0] in_op;
    logic [7:0] in_x, in_y;
    logic       in_on;
    logic [2:0] in_page;

    logic [oled_fb_pkg::ROW_W-1:0] frow, srow;
    logic [7:0]                    fbyte, sbyte, first8, cmd_byte;
    logic [oled_fb_pkg::CW-1:0]    data_rem;
    logic [oled_fb_pkg::CNT_W-1:0] dat_chunk, cmd_rem, cmd_chunk;
    logic                          diff;

    assign in_op   = s_tdata[1:0];
    assign in_x    = s_tdata[9:2];
    assign in_y    = s_tdata[17:10];
    assign in_on   = s_tdata[18];
    assign in_page = s_tdata[21:19];

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_EMIT);
    assign m_tdata  = {4'b0, 64'(pack_reg), chunk_reg};
    assign m_tuser  = is_data_reg;
    assign m_tlast  = mlast_reg;

    assign frow  = frd_vld_reg ? frd_data_reg : '0;
    assign srow  = srd_vld_reg ? srd_data_reg : '0;
    assign fbyte = frow[page_reg*8 +: 8];
    assign sbyte = srow[page_reg*8 +: 8];
    assign diff  = (fbyte != sbyte);

    assign first8 = 8'(first_reg);

    always_comb begin
        case (cidx_reg)
            oled_fb_pkg::CI_PAGE:   cmd_byte = oled_fb_pkg::CMD_PAGE + 8'(page_reg);
            oled_fb_pkg::CI_COL_LO: cmd_byte = oled_fb_pkg::CMD_COL_LO
                                               | (first8 & oled_fb_pkg::NIB_MASK);
            oled_fb_pkg::CI_COL_HI: cmd_byte = oled_fb_pkg::CMD_COL_HI
                                               | ((first8 >> 4) & oled_fb_pkg::NIB_MASK);
            default:                cmd_byte = '0;
        endcase
    end

    assign data_rem   = oled_fb_pkg::CW'(last_reg) + oled_fb_pkg::CW'(1) - col_reg;
    assign dat_chunk  = (data_rem > oled_fb_pkg::CW'(oled_fb_pkg::BYTES_PER_RESULT))
                        ? oled_fb_pkg::CNT_W'(oled_fb_pkg::BYTES_PER_RESULT)
                        : oled_fb_pkg::CNT_W'(data_rem);
    assign cmd_rem    = oled_fb_pkg::CNT_W'(oled_fb_pkg::CMD_BYTES)
                        - oled_fb_pkg::CNT_W'(cidx_reg);
    assign cmd_chunk  = (cmd_rem > oled_fb_pkg::CNT_W'(oled_fb_pkg::BYTES_PER_RESULT))
                        ? oled_fb_pkg::CNT_W'(oled_fb_pkg::BYTES_PER_RESULT)
                        : cmd_rem;

    always_comb begin
        state_next   = state_reg;
        x_next       = x_reg;
        ypage_next   = ypage_reg;
        ybit_next    = ybit_reg;
        on_next      = on_reg;
        page_next    = page_reg;
        partial_next = partial_reg;
        col_next     = col_reg;
        rcol_next    = rcol_reg;
        rvld_next    = 1'b0;
        found_next   = found_reg;
        first_next   = first_reg;
        last_next    = last_reg;
        cidx_next    = cidx_reg;
        chunk_next   = chunk_reg;
        k_next       = k_reg;
        iss_next     = iss_reg;
        pack_next    = pack_reg;
        is_data_next = is_data_reg;
        mlast_next   = mlast_reg;
        rd_en        = 1'b0;
        rd_addr      = col_reg[oled_fb_pkg::CAW-1:0];
        fwr_en       = 1'b0;
        fwr_addr     = x_reg;
        fwr_data     = frow;
        swr_en       = 1'b0;
        swr_addr     = rcol_reg;
        swr_data     = srow;
        fclr         = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    case (oled_fb_pkg::op_t'(in_op))
                        oled_fb_pkg::OP_DRAW: begin
                            if (32'(in_x) < oled_fb_pkg::COLUMNS
                                && 32'(in_y) < 8 * oled_fb_pkg::PAGES) begin
                                x_next     = oled_fb_pkg::CAW'(in_x);
                                ypage_next = oled_fb_pkg::PAW'(in_y >> 3);
                                ybit_next  = in_y[2:0];
                                on_next    = in_on;
                                state_next = ST_DRAW_RD;
                            end
                        end
                        oled_fb_pkg::OP_CLEAR: begin
                            fclr = 1'b1;
                        end
                        default: begin
                            if (32'(in_page) < oled_fb_pkg::PAGES) begin
                                page_next    = oled_fb_pkg::PAW'(in_page);
                                partial_next = (oled_fb_pkg::op_t'(in_op)
                                                == oled_fb_pkg::OP_PARTIAL);
                                if (oled_fb_pkg::op_t'(in_op) == oled_fb_pkg::OP_PARTIAL) begin
                                    col_next   = '0;
                                    found_next = 1'b0;
                                    state_next = ST_SCAN;
                                end else begin
                                    first_next = '0;
                                    last_next  = oled_fb_pkg::CAW'(oled_fb_pkg::COLUMNS - 1);
                                    cidx_next  = oled_fb_pkg::CI_PAGE;
                                    chunk_next = oled_fb_pkg::CNT_W'(
                                                     oled_fb_pkg::FIRST_CMD_CHUNK);
                                    k_next     = '0;
                                    pack_next  = '0;
                                    state_next = ST_CGATHER;
                                end
                            end
                        end
                    endcase
                end
            end
            ST_DRAW_RD: begin
                rd_en      = 1'b1;
                rd_addr    = x_reg;
                state_next = ST_DRAW_WR;
            end
            ST_DRAW_WR: begin
                fwr_en = 1'b1;
                fwr_data[ypage_reg*8 + ybit_reg] = on_reg;
                state_next = ST_IDLE;
            end
            ST_SCAN: begin
                if (col_reg < oled_fb_pkg::CW'(oled_fb_pkg::COLUMNS)) begin
                    rd_en     = 1'b1;
                    col_next  = col_reg + 1'b1;
                    rcol_next = col_reg[oled_fb_pkg::CAW-1:0];
                    rvld_next = 1'b1;
                end
                if (rvld_reg) begin
                    // only this page's byte is replaced; the other bytes of the shadow row are written back as read
                    swr_en = 1'b1;
                    swr_data[page_reg*8 +: 8] = fbyte;
                    if (diff) begin
                        if (!found_reg) begin
                            first_next = rcol_reg;
                        end
                        last_next  = rcol_reg;
                        found_next = 1'b1;
                    end
                    if (rcol_reg == oled_fb_pkg::CAW'(oled_fb_pkg::COLUMNS - 1)) begin
                        if (found_next) begin
                            cidx_next  = oled_fb_pkg::CI_PAGE;
                            chunk_next = oled_fb_pkg::CNT_W'(oled_fb_pkg::FIRST_CMD_CHUNK);
                            k_next     = '0;
                            pack_next  = '0;
                            state_next = ST_CGATHER;
                        end else begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            ST_CGATHER: begin
                pack_next[k_reg[oled_fb_pkg::KW-1:0]] = cmd_byte;
                cidx_next = cidx_reg + 1'b1;
                k_next    = k_reg + 1'b1;
                if (k_reg + 1'b1 == chunk_reg) begin
                    is_data_next = 1'b0;
                    mlast_next   = 1'b0;
                    state_next   = ST_EMIT;
                end
            end
            ST_DGATHER: begin
                if (iss_reg < chunk_reg) begin
                    rd_en     = 1'b1;
                    col_next  = col_reg + 1'b1;
                    iss_next  = iss_reg + 1'b1;
                    rvld_next = 1'b1;
                end
                if (rvld_reg) begin
                    pack_next[k_reg[oled_fb_pkg::KW-1:0]] = fbyte;
                    k_next = k_reg + 1'b1;
                    if (k_reg + 1'b1 == chunk_reg) begin
                        is_data_next = 1'b1;
                        mlast_next   = (col_reg > oled_fb_pkg::CW'(last_reg));
                        state_next   = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (m_tready) begin
                    k_next    = '0;
                    iss_next  = '0;
                    pack_next = '0;
                    if (mlast_reg) begin
                        state_next = ST_IDLE;
                    end else if (!is_data_reg
                                 && cidx_reg != oled_fb_pkg::CI_DONE) begin
                        chunk_next = cmd_chunk;
                        state_next = ST_CGATHER;
                    end else begin
                        if (!is_data_reg) begin
                            col_next = oled_fb_pkg::CW'(first_reg);
                        end
                        state_next = ST_DGATHER;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // each data chunk is sized once col_reg has been loaded with that chunk's first column
    logic start_chunk_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            rvld_reg        <= 1'b0;
            start_chunk_reg <= 1'b0;
        end else begin
            state_reg       <= state_next;
            rvld_reg        <= rvld_next;
            start_chunk_reg <= (state_reg == ST_EMIT) && m_tready && !mlast_reg
                               && (is_data_reg || cidx_reg == oled_fb_pkg::CI_DONE);
        end
    end

    always_ff @(posedge aclk) begin
        x_reg       <= x_next;
        ypage_reg   <= ypage_next;
        ybit_reg    <= ybit_next;
        on_reg      <= on_next;
        page_reg    <= page_next;
        partial_reg <= partial_next;
        col_reg     <= col_next;
        rcol_reg    <= rcol_next;
        found_reg   <= found_next;
        first_reg   <= first_next;
        last_reg    <= last_next;
        cidx_reg    <= cidx_next;
        k_reg       <= k_next;
        iss_reg     <= iss_next;
        pack_reg    <= pack_next;
        is_data_reg <= is_data_next;
        mlast_reg   <= mlast_next;
        if (start_chunk_reg && state_reg == ST_DGATHER) begin
            chunk_reg <= dat_chunk;
        end else begin
            chunk_reg <= chunk_next;
        end
    end

    // valid flags stand in for the zero reset of both stores
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_vld_reg  <= '0;
            shadow_vld_reg <= '0;
        end else begin
            if (fclr) begin
                frame_vld_reg <= '0;
            end else if (fwr_en) begin
                frame_vld_reg[fwr_addr] <= 1'b1;
            end
            if (swr_en) begin
                shadow_vld_reg[swr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fwr_en) begin
            frame_mem[fwr_addr] <= fwr_data;
        end
        if (rd_en) begin
            frd_data_reg <= frame_mem[rd_addr];
            frd_vld_reg  <= frame_vld_reg[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (swr_en) begin
            shadow_mem[swr_addr] <= swr_data;
        end
        if (rd_en) begin
            srd_data_reg <= shadow_mem[rd_addr];
            srd_vld_reg  <= shadow_vld_reg[rd_addr];
        end
    end

endmodule
